// ===== hdl/buddy_page_allocator_assert.svh =====
//------------------------------------------------------------------------------
// buddy_page_allocator_assert.svh
// Assertion macros shared by the buddy page allocator RTL.
//------------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Implication checked in the same cycle.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("buddy_page_allocator: assertion failed");

// Implication checked in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("buddy_page_allocator: assertion failed");

`endif

// ===== hdl/bpa_pkg.sv =====
//------------------------------------------------------------------------------
// bpa_pkg
// Shared constants and beat types for the buddy page allocator.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   localparam int PAGE_COUNT  = 1024;
   localparam int LEVEL_COUNT = 11;
   localparam int PAGE_W      = $clog2(PAGE_COUNT);
   localparam int LINK_W      = PAGE_W + 1;
   localparam int LV_W        = $clog2(LEVEL_COUNT);
   localparam int ORDER_W     = 4;
   localparam int FUNC_W      = 2;
   localparam int BM_DEPTH    = PAGE_COUNT + 1;

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(PAGE_COUNT);
   localparam logic [LV_W-1:0]   TOP_LV   = LV_W'(LEVEL_COUNT - 1);

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ORDER_W-1:0] order;
      logic [PAGE_W-1:0]  page_index;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [PAGE_W-1:0] block_page;
      logic [LINK_W-1:0] used_pages;
      logic [LINK_W-1:0] peak_used;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/buddy_page_allocator.sv =====
// Allocate searches the levels upward from the requested order and fails when no
//   level holds a free block; else it unlinks the block, marks it in the bitmap and
//   splits it down to the requested order. Free and add merge with the free buddy
//   level by level; rejected requests respond with no memory access. One request at
//   a time; each level costs a read-modify-write of the bitmap and link memories.
// Reset: a clearing pass writes all PAGE_COUNT + 1 bitmap rows to all ones; busy
//   is high during it. Results are strobed for one cycle; the receiver cannot stall.
//------------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy page allocator with per-level free bitmap and ordered free lists.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_page_allocator_assert.svh"

module buddy_page_allocator
   import bpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   typedef enum logic [12:0] {
      S_CLEAR   = 13'b0000000000001,
      S_IDLE    = 13'b0000000000010,
      S_SEARCH  = 13'b0000000000100,
      S_UL_RD   = 13'b0000000001000,
      S_UL_WR   = 13'b0000000010000,
      S_BM_RD   = 13'b0000000100000,
      S_BM_WR   = 13'b0000001000000,
      S_SPLIT   = 13'b0000010000000,
      S_AP_P    = 13'b0000100000000,
      S_AP_T    = 13'b0001000000000,
      S_FR_TEST = 13'b0010000000000,
      S_FR_RD   = 13'b0100000000000,
      S_FR_CHK  = 13'b1000000000000
   } state_type;

   // respond happens from a dedicated flag rather than a state
   state_type         state_ff, state_in;
   logic              done_ff, done_in;
   logic [LV_W-1:0]   lv_ff, lv_in;
   logic [LV_W-1:0]   ord_ff, ord_in;
   logic              alloc_ff, alloc_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] row_ff, row_in;
   logic [LINK_W-1:0] idx_ff, idx_in;
   logic              val_ff, val_in;
   logic [LINK_W-1:0] c_ff, c_in;
   logic [LINK_W-1:0] clr_ff, clr_in;
   logic [LINK_W-1:0] used_ff, used_in;
   logic [LINK_W-1:0] peak_ff, peak_in;
   logic              ok_ff, ok_in;
   logic [LINK_W-1:0] head_ff [LEVEL_COUNT];
   logic [LINK_W-1:0] head_in [LEVEL_COUNT];
   logic [LINK_W-1:0] tail_ff [LEVEL_COUNT];
   logic [LINK_W-1:0] tail_in [LEVEL_COUNT];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic                   bm_we, bm_re;
   logic [LINK_W-1:0]      bm_waddr, bm_raddr;
   logic [LEVEL_COUNT-1:0] bm_wdata, bm_rdata, bm_bit;
   logic                   nx_we, nx_re, pv_we;
   logic [PAGE_W-1:0]      nx_waddr, pv_waddr, ln_raddr;
   logic [LINK_W-1:0]      nx_wdata, pv_wdata, nx_rdata, pv_rdata;

   logic [LINK_W-1:0] t_link, h_link, pr, nx, b_page, sz_req;
   logic [LINK_W:0]   used_sum;
   logic              t_ok;
   logic [LV_W-1:0]   lv_dn;

   bpa_ram #(.WIDTH(LEVEL_COUNT), .DEPTH(BM_DEPTH)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_en   (bm_re),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_next (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_en   (nx_re),
      .rd_addr (ln_raddr),
      .rd_data (nx_rdata)
   );

   bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_prev (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_en   (nx_re),
      .rd_addr (ln_raddr),
      .rd_data (pv_rdata)
   );

   always_comb begin
      t_link   = tail_ff[lv_ff];
      h_link   = head_ff[lv_ff];
      t_ok     = t_link < NIL_LINK;
      pr       = (pv_rdata < NIL_LINK) ? pv_rdata : NIL_LINK;
      nx       = (nx_rdata < NIL_LINK) ? nx_rdata : NIL_LINK;
      bm_bit   = LEVEL_COUNT'(1) << lv_ff;
      lv_dn    = lv_ff - LV_W'(1);
      b_page   = c_ff + (LINK_W'(1) << lv_dn);
      sz_req   = LINK_W'(1) << req_item.order;
      used_sum = {1'b0, used_ff} + {1'b0, LINK_W'(1) << ord_ff};

      state_in     = state_ff;
      done_in      = 1'b0;
      lv_in        = lv_ff;
      ord_in       = ord_ff;
      alloc_in     = alloc_ff;
      cur_in       = cur_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      c_in         = c_ff;
      clr_in       = clr_ff;
      used_in      = used_ff;
      peak_in      = peak_ff;
      ok_in        = ok_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      bm_we    = 1'b0;
      bm_re    = 1'b0;
      bm_waddr = row_ff;
      bm_raddr = row_ff;
      bm_wdata = bm_rdata;
      nx_we    = 1'b0;
      nx_re    = 1'b0;
      pv_we    = 1'b0;
      nx_waddr = cur_ff[PAGE_W-1:0];
      pv_waddr = cur_ff[PAGE_W-1:0];
      ln_raddr = cur_ff[PAGE_W-1:0];
      nx_wdata = NIL_LINK;
      pv_wdata = NIL_LINK;

      if (done_ff) begin
         rsp_valid_in        = 1'b1;
         rsp_in.ok           = ok_ff;
         rsp_in.block_page   = ok_ff && alloc_ff ? c_ff[PAGE_W-1:0] : '0;
         rsp_in.used_pages   = used_ff;
         rsp_in.peak_used    = peak_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            bm_we    = 1'b1;
            bm_waddr = clr_ff;
            bm_wdata = '1;
            clr_in   = clr_ff + LINK_W'(1);
            if (clr_ff == LINK_W'(BM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start && !done_ff) begin
               ok_in    = 1'b1;
               alloc_in = 1'b0;
               ord_in   = req_item.order;
               case (req_item.func)
                  FUNC_ALLOC: begin
                     alloc_in = 1'b1;
                     lv_in    = req_item.order;
                     if (req_item.order < ORDER_W'(LEVEL_COUNT)) begin
                        state_in = S_SEARCH;
                     end else begin
                        ok_in   = 1'b0;
                        done_in = 1'b1;
                     end
                  end
                  FUNC_FREE: begin
                     if (req_item.order < ORDER_W'(LEVEL_COUNT)) begin
                        lv_in    = req_item.order;
                        idx_in   = {1'b0, req_item.page_index} >> req_item.order;
                        used_in  = (used_ff < sz_req) ? '0 : used_ff - sz_req;
                        state_in = S_FR_TEST;
                     end else begin
                        ok_in   = 1'b0;
                        done_in = 1'b1;
                     end
                  end
                  FUNC_ADD: begin
                     lv_in    = '0;
                     idx_in   = {1'b0, req_item.page_index};
                     state_in = S_FR_TEST;
                  end
                  default: begin
                     ok_in   = 1'b0;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (h_link < NIL_LINK) begin
               c_in     = h_link;
               cur_in   = h_link;
               row_in   = h_link >> lv_ff;
               val_in   = 1'b1;
               state_in = S_UL_RD;
            end else if (lv_ff == TOP_LV) begin
               ok_in    = 1'b0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               lv_in = lv_ff + LV_W'(1);
            end
         end
         S_UL_RD: begin
            nx_re    = 1'b1;
            state_in = S_UL_WR;
         end
         S_UL_WR: begin
            if (pr == NIL_LINK) begin
               head_in[lv_ff] = nx;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = pr[PAGE_W-1:0];
               nx_wdata = nx;
            end
            if (nx == NIL_LINK) begin
               tail_in[lv_ff] = pr;
            end else begin
               pv_we    = 1'b1;
               pv_waddr = nx[PAGE_W-1:0];
               pv_wdata = pr;
            end
            if (alloc_ff) begin
               state_in = S_BM_RD;
            end else begin
               idx_in   = idx_ff >> 1;
               lv_in    = lv_ff + LV_W'(1);
               state_in = S_FR_TEST;
            end
         end
         S_BM_RD: begin
            bm_re    = 1'b1;
            state_in = S_BM_WR;
         end
         S_BM_WR: begin
            bm_we    = 1'b1;
            bm_wdata = val_ff ? (bm_rdata | bm_bit) : (bm_rdata & ~bm_bit);
            state_in = alloc_ff ? S_SPLIT : S_AP_P;
         end
         S_SPLIT: begin
            if (lv_ff > ord_ff) begin
               lv_in = lv_dn;
               if (b_page < NIL_LINK) begin
                  cur_in   = b_page;
                  row_in   = b_page >> lv_dn;
                  val_in   = 1'b0;
                  state_in = S_AP_P;
               end
            end else begin
               used_in  = (used_sum > (LINK_W+1)'(PAGE_COUNT)) ? NIL_LINK
                                                                : used_sum[LINK_W-1:0];
               peak_in  = (used_in > peak_ff) ? used_in : peak_ff;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_AP_P: begin
            nx_we    = 1'b1;
            nx_wdata = NIL_LINK;
            pv_we    = 1'b1;
            pv_wdata = t_ok ? t_link : NIL_LINK;
            state_in = S_AP_T;
         end
         S_AP_T: begin
            if (t_ok) begin
               nx_we    = 1'b1;
               nx_waddr = t_link[PAGE_W-1:0];
               nx_wdata = cur_ff;
            end else begin
               head_in[lv_ff] = cur_ff;
            end
            tail_in[lv_ff] = cur_ff;
            if (alloc_ff) begin
               state_in = S_BM_RD;
            end else begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FR_TEST: begin
            if (lv_ff == TOP_LV) begin
               row_in   = idx_ff;
               val_in   = 1'b0;
               cur_in   = idx_ff << lv_ff;
               state_in = S_BM_RD;
            end else begin
               row_in   = idx_ff ^ LINK_W'(1);
               state_in = S_FR_RD;
            end
         end
         S_FR_RD: begin
            bm_re    = 1'b1;
            state_in = S_FR_CHK;
         end
         S_FR_CHK: begin
            if (bm_rdata[lv_ff]) begin
               row_in   = idx_ff;
               val_in   = 1'b0;
               cur_in   = idx_ff << lv_ff;
               state_in = S_BM_RD;
            end else begin
               bm_we    = 1'b1;
               bm_wdata = bm_rdata | bm_bit;
               cur_in   = row_ff << lv_ff;
               state_in = S_UL_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         done_ff      <= 1'b0;
         clr_ff       <= '0;
         used_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVEL_COUNT; i++) begin
            head_ff[i] <= NIL_LINK;
            tail_ff[i] <= NIL_LINK;
         end
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff    <= lv_in;
      ord_ff   <= ord_in;
      alloc_ff <= alloc_in;
      cur_ff   <= cur_in;
      row_ff   <= row_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      c_ff     <= c_in;
      ok_ff    <= ok_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE) || done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `BPA_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   `BPA_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_item.ok, rsp_item.block_page == '0)
   `BPA_ASSERT_NOW(a_peak_bound, rsp_valid, rsp_item.used_pages <= rsp_item.peak_used)
   `BPA_ASSERT_NOW(a_used_bound, 1'b1, used_ff <= NIL_LINK)

endmodule

`default_nettype wire

// ===== hdl/bpa_ram.sv =====
//------------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM, one write port, registered read port.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
